// File: hw/rtl/pfe_pkg.sv
// Package for the postfix expression evaluator.
// Holds stack sizing, symbol codes, result type and the controller-to-datapath bundles.
package pfe_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] SYM_ZERO = 8'd48;
    localparam logic [7:0] SYM_NINE = 8'd57;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_MOD  = 8'h25;

    localparam logic [31:0] UNDERFLOW_VALUE = 32'hFFFF_FF9C;

    typedef enum logic [2:0] {
        OP_PUSH_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic       load_sym;
        logic       pop_right;
        logic       pop_left;
        logic       push_digit;
        logic       push_alu;
        logic       mul_start;
        logic       div_start;
        logic       set_bad;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic div_done;
        logic mem_busy;
    } t_status;

    typedef struct packed {
        logic [31:0] value;
        logic        stack_empty;
        logic        underflow;
        logic        overflow;
        logic        divide_by_zero;
        logic        bad_symbol;
    } t_result;

endpackage

// File: hw/rtl/pfe_divider.sv
// Radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on pfe_pkg.
module pfe_divider
    import pfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [31:0] o_remainder
);

    logic        r_busy;
    logic [5:0]  r_count;
    logic [31:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic        r_qneg;
    logic        r_rneg;
    logic        r_done;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= 6'd32;
                r_quo   <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
                r_div   <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
                r_rem   <= '0;
                r_qneg  <= i_dividend[31] ^ i_divisor[31];
                r_rneg  <= i_dividend[31];
            end else if (r_busy) begin
                if (w_diff[32]) begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end else begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[30:0], 1'b1};
                end
                r_count <= r_count - 6'd1;
                if (r_count == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_qneg ? (32'd0 - r_quo) : r_quo;
    assign o_remainder = r_rneg ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

endmodule

// File: hw/rtl/pfe_datapath.sv
// Datapath: operand stack memory, count, sticky flags, multiplier and divider.
// Depends on pfe_pkg and pfe_divider.
module pfe_datapath
    import pfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_symbol,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_result     o_result
);

    logic [31:0]      r_mem [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_top;
    logic [7:0]       r_sym;
    logic [31:0]      r_right;
    logic [31:0]      r_left;
    logic [31:0]      r_prod;
    logic             r_uf, r_of, r_dz, r_bad;
    logic             r_rd_pend;
    logic [31:0]      r_rd_data;
    logic [31:0]      w_pop_val;
    logic             w_empty;
    logic             w_push;
    logic [31:0]      w_push_val;
    logic             w_div_done;
    logic [31:0]      w_q, w_r;
    t_op              w_op;

    // The top of stack lives in r_top; entries below it are in memory.
    assign w_empty   = (r_count == '0);
    assign w_pop_val = w_empty ? UNDERFLOW_VALUE : r_top;

    always_comb begin
        if (r_sym >= SYM_ZERO && r_sym <= SYM_NINE) w_op = OP_PUSH_DIGIT;
        else begin
            case (r_sym)
                SYM_ADD: w_op = OP_ADD;
                SYM_SUB: w_op = OP_SUB;
                SYM_MUL: w_op = OP_MUL;
                SYM_DIV: w_op = OP_DIV;
                SYM_MOD: w_op = OP_MOD;
                default: w_op = OP_BAD;
            endcase
        end
    end

    pfe_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_left),
        .i_divisor   (r_right),
        .o_done      (w_div_done),
        .o_quotient  (w_q),
        .o_remainder (w_r)
    );

    always_comb begin
        w_push     = i_cmd.push_digit | i_cmd.push_alu;
        w_push_val = 32'(r_sym - SYM_ZERO);
        if (i_cmd.push_alu) begin
            case (w_op)
                OP_ADD:  w_push_val = r_left + r_right;
                OP_SUB:  w_push_val = r_left - r_right;
                OP_MUL:  w_push_val = r_prod;
                OP_DIV:  w_push_val = (r_right == '0) ? '0 : w_q;
                OP_MOD:  w_push_val = (r_right == '0) ? '0 : w_r;
                default: w_push_val = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sym) r_sym <= i_symbol;
        if (i_cmd.mul_start) r_prod <= r_left * r_right;
        if (i_cmd.pop_right) r_right <= w_pop_val;
        if (i_cmd.pop_left)  r_left  <= w_pop_val;
        r_rd_data <= r_mem[r_count[PTR_W-1:0] - PTR_W'(2)];
        if (w_push && r_count != '0 && r_count != CNT_W'(STACK_DEPTH))
            r_mem[PTR_W'(r_count - CNT_W'(1))] <= r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_rd_pend <= 1'b0;
            r_uf <= 1'b0; r_of <= 1'b0; r_dz <= 1'b0; r_bad <= 1'b0;
        end else begin
            r_rd_pend <= 1'b0;
            if (r_rd_pend) r_top <= r_rd_data;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_uf <= 1'b0; r_of <= 1'b0; r_dz <= 1'b0; r_bad <= 1'b0;
            end else if (i_cmd.pop_right || i_cmd.pop_left) begin
                if (w_empty) r_uf <= 1'b1;
                else begin
                    r_count <= r_count - CNT_W'(1);
                    // refill top from memory; read address set up this cycle
                    if (r_count > CNT_W'(1)) r_rd_pend <= 1'b1;
                end
            end else if (w_push) begin
                if (r_count == CNT_W'(STACK_DEPTH)) r_of <= 1'b1;
                else begin
                    r_count <= r_count + CNT_W'(1);
                    r_top   <= w_push_val;
                end
            end
            if (i_cmd.push_alu && (w_op == OP_DIV || w_op == OP_MOD) && r_right == '0)
                r_dz <= 1'b1;
            if (i_cmd.set_bad) r_bad <= 1'b1;
        end
    end

    assign o_status.op       = w_op;
    assign o_status.div_done = w_div_done;
    assign o_status.mem_busy = r_rd_pend;

    assign o_result.value          = w_empty ? '0 : r_top;
    assign o_result.stack_empty    = w_empty;
    assign o_result.underflow      = r_uf;
    assign o_result.overflow       = r_of;
    assign o_result.divide_by_zero = r_dz;
    assign o_result.bad_symbol     = r_bad;

endmodule

// File: hw/rtl/pfe_controller.sv
// Controller state machine sequencing pops, operations and pushes per symbol.
// Depends on pfe_pkg.
module pfe_controller
    import pfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_capture,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POP_R, S_WAIT_R, S_POP_L, S_WAIT_L,
        S_EXEC, S_DIV, S_PUSH, S_END
    } t_state;

    t_state r_state;
    logic   r_last;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd = '0;
        o_cmd.load_sym = w_accept;
        o_capture = 1'b0;
        unique case (r_state)
            S_DECODE: if (i_status.op == OP_PUSH_DIGIT) o_cmd.push_digit = 1'b1;
            S_POP_R:  o_cmd.pop_right = 1'b1;
            S_POP_L:  o_cmd.pop_left = 1'b1;
            S_EXEC: begin
                o_cmd.mul_start = (i_status.op == OP_MUL);
                o_cmd.div_start = (i_status.op == OP_DIV) || (i_status.op == OP_MOD);
                o_cmd.set_bad   = (i_status.op == OP_BAD);
            end
            S_PUSH:   o_cmd.push_alu = 1'b1;
            S_END: begin
                o_capture = 1'b1;
                o_cmd.clear = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && r_state != S_END) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_last  <= i_in_last;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    if (i_status.op == OP_PUSH_DIGIT) r_state <= r_last ? S_END : S_IDLE;
                    else r_state <= S_POP_R;
                end
                S_POP_R:  r_state <= S_WAIT_R;
                S_WAIT_R: if (!i_status.mem_busy) r_state <= S_POP_L;
                S_POP_L:  r_state <= S_WAIT_L;
                S_WAIT_L: if (!i_status.mem_busy) r_state <= S_EXEC;
                S_EXEC: begin
                    if (i_status.op == OP_BAD) r_state <= r_last ? S_END : S_IDLE;
                    else if (i_status.op == OP_DIV || i_status.op == OP_MOD) r_state <= S_DIV;
                    else r_state <= S_PUSH;
                end
                S_DIV:    if (i_status.div_done) r_state <= S_PUSH;
                S_PUSH:   r_state <= r_last ? S_END : S_IDLE;
                S_END: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/postfix_expression_evaluator_top.sv
// Postfix expression evaluator: s_axis takes one character a transfer,
// m_axis returns the value and flags after the character marked tlast.
// Channels: s_axis_tdata = symbol, s_axis_tlast = last. m_axis_tdata packs
// value and flags. One character is in work at a time. A digit is pushed
// straight after decode; + - and * pop two operands, execute and push; / and
// % also wait for the radix-2 divider (one quotient bit a cycle). Each stack
// pop may wait on the stack memory read port that refills the cached top
// entry.
// After the character marked tlast the result is captured into an output
// register and sits there until taken; a new character is accepted while it
// waits only if that register will be free (tready of m_axis high or no
// result pending).
// Reset (synchronous, i_rst_n low) empties the stack, clears flags and
// drops any pending result; no clearing pass is needed.
// A stalled receiver holds the result and blocks further characters.
module postfix_expression_evaluator_top
    import pfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] value, [32] stack_empty, [33] underflow,
                                        // [34] overflow, [35] divide_by_zero, [36] bad_symbol
);

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_capture;
    t_result r_out;

    pfe_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_capture   (w_capture),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pfe_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_symbol (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (w_capture) r_out <= w_result;
    end

    assign m_axis_tdata = {3'b000, r_out.bad_symbol, r_out.divide_by_zero, r_out.overflow,
                           r_out.underflow, r_out.stack_empty, r_out.value};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[32] || m_axis_tdata[31:0] == '0))
        else $error("empty stack with nonzero value");
    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwritten");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.pop_right, w_cmd.pop_left, w_cmd.push_digit, w_cmd.push_alu}))
        else $error("conflicting stack commands");

endmodule
